// ===== hdl/mrfr_pkg.sv =====
// Shared types, constants and the CRC byte update for the Modbus RTU frame receiver.
package mrfr_pkg;

    // Result status codes
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_IN_FRAME = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_CRC_BAD  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_BUSY     = 3'd5;
    localparam logic [2:0] ST_RELEASED = 3'd6;

    // Receiver phases
    localparam logic [1:0] PH_WAIT_ADDR = 2'd0;
    localparam logic [1:0] PH_HEADER    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD   = 2'd2;

    // Protocol constants
    localparam logic [7:0]  FC_WRITE_MULTI   = 8'h10;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  ADDR_RESET       = 8'd1;
    localparam logic [8:0]  WM_OVERHEAD      = 9'd9;
    localparam int          MAX_FRAME_BYTES  = 252;

    // Header byte offsets
    localparam logic [7:0] OFS_FUNC    = 8'd1;
    localparam logic [7:0] OFS_REG_HI  = 8'd2;
    localparam logic [7:0] OFS_REG_LO  = 8'd3;
    localparam logic [7:0] OFS_QTY_HI  = 8'd4;
    localparam logic [7:0] OFS_QTY_LO  = 8'd5;
    localparam logic [7:0] OFS_COUNT   = 8'd6;
    localparam logic [7:0] OFS_CRC_HI  = 8'd7;

    // Item handed from front to back
    typedef struct packed {
        logic       is_release;
        logic       addr_hit;
        logic [7:0] data;
    } t_item;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mrfr_front.sv =====
// Front end: input acceptance, address register and byte classification.
module mrfr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                i_q_ready,
    output logic                o_q_push,
    output mrfr_pkg::t_item     o_q_item
);

    logic [7:0] r_slave_addr;

    // Slave address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mrfr_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            r_slave_addr <= i_cfg_wdata;
        end
    end

    // Accept while the queue has room
    assign s_axis_tready = i_q_ready;
    assign o_q_push      = s_axis_tvalid && i_q_ready;

    // Classify: release command, or byte with address match flag
    always_comb begin
        o_q_item.is_release = s_axis_tuser;
        o_q_item.addr_hit   = (s_axis_tdata == r_slave_addr);
        o_q_item.data       = s_axis_tdata;
    end

endmodule

// ===== hdl/mrfr_queue.sv =====
// Two-entry queue between the front end and the frame engine.
module mrfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mrfr_pkg::t_item     i_item,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output mrfr_pkg::t_item     o_item
);

    localparam int DEPTH = 2;

    mrfr_pkg::t_item r_mem [DEPTH];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/mrfr_back.sv =====
// Frame engine: phase tracking, header capture, CRC check and the result register.
module mrfr_back #(
    parameter int MAX_FRAME_BYTES = mrfr_pkg::MAX_FRAME_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mrfr_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,
    output logic [2:0]          m_axis_tuser
);

    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);

    // Frame state
    logic [1:0]  r_phase,  n_phase;
    logic [7:0]  r_pos,    n_pos;
    logic [8:0]  r_exp,    n_exp;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_prev,   n_prev;
    logic        r_busy,   n_busy;
    logic [7:0]  r_hfunc,  n_hfunc;
    logic [15:0] r_hreg,   n_hreg;
    logic [15:0] r_hqty,   n_hqty;
    logic [7:0]  r_hcnt,   n_hcnt;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_value,  n_value;
    logic [7:0]  r_index,  n_index;

    logic [7:0]  b;
    logic [15:0] crc_fed;
    logic        crc_ok;
    logic [8:0]  wm_len;
    logic [8:0]  pos_p1;
    logic [8:0]  pos_p2;

    assign o_q_pop = i_q_valid && (!r_out_valid || m_axis_tready);

    assign b       = i_q_item.data;
    assign crc_fed = mrfr_pkg::crc_byte(r_crc, b);
    assign crc_ok  = (r_prev == r_crc[7:0]) && (b == r_crc[15:8]);
    assign wm_len  = mrfr_pkg::WM_OVERHEAD + {1'b0, b};
    assign pos_p1  = {1'b0, r_pos} + 9'd1;
    assign pos_p2  = {1'b0, r_pos} + 9'd2;

    // Next-state and result for one item
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_exp    = r_exp;
        n_crc    = r_crc;
        n_prev   = r_prev;
        n_busy   = r_busy;
        n_hfunc  = r_hfunc;
        n_hreg   = r_hreg;
        n_hqty   = r_hqty;
        n_hcnt   = r_hcnt;
        n_status = mrfr_pkg::ST_IGNORED;
        n_value  = b;
        n_index  = 8'd0;

        if (i_q_item.is_release) begin
            n_busy   = 1'b0;
            n_phase  = mrfr_pkg::PH_WAIT_ADDR;
            n_pos    = 8'd0;
            n_status = mrfr_pkg::ST_RELEASED;
            n_value  = 8'd0;
        end else if (r_busy) begin
            n_status = mrfr_pkg::ST_BUSY;
        end else begin
            unique case (r_phase)
                mrfr_pkg::PH_WAIT_ADDR: begin
                    if (i_q_item.addr_hit) begin
                        n_hfunc  = 8'd0;
                        n_hreg   = 16'd0;
                        n_hqty   = 16'd0;
                        n_hcnt   = 8'd0;
                        n_crc    = mrfr_pkg::crc_byte(mrfr_pkg::CRC_INIT, b);
                        n_pos    = 8'd1;
                        n_phase  = mrfr_pkg::PH_HEADER;
                        n_status = mrfr_pkg::ST_IN_FRAME;
                    end
                end
                mrfr_pkg::PH_HEADER: begin
                    n_index  = r_pos;
                    n_status = mrfr_pkg::ST_IN_FRAME;
                    // Header field capture
                    unique case (r_pos)
                        mrfr_pkg::OFS_FUNC:   n_hfunc       = b;
                        mrfr_pkg::OFS_REG_HI: n_hreg[15:8]  = b;
                        mrfr_pkg::OFS_REG_LO: n_hreg[7:0]   = b;
                        mrfr_pkg::OFS_QTY_HI: n_hqty[15:8]  = b;
                        mrfr_pkg::OFS_QTY_LO: n_hqty[7:0]   = b;
                        mrfr_pkg::OFS_COUNT: begin
                            if (r_hfunc == mrfr_pkg::FC_WRITE_MULTI) begin
                                n_hcnt = b;
                            end
                        end
                        default: ;
                    endcase
                    // Position and CRC progress
                    if (r_pos < mrfr_pkg::OFS_COUNT) begin
                        n_crc = crc_fed;
                        n_pos = pos_p1[7:0];
                    end else if (r_pos == mrfr_pkg::OFS_COUNT &&
                                 r_hfunc == mrfr_pkg::FC_WRITE_MULTI) begin
                        n_crc = crc_fed;
                        n_exp = wm_len;
                        if (wm_len > MAX_LEN) begin
                            n_status = mrfr_pkg::ST_TOO_LONG;
                            n_phase  = mrfr_pkg::PH_WAIT_ADDR;
                            n_pos    = 8'd0;
                        end else begin
                            n_phase  = mrfr_pkg::PH_PAYLOAD;
                            n_pos    = mrfr_pkg::OFS_CRC_HI;
                        end
                    end else if (r_pos == mrfr_pkg::OFS_COUNT) begin
                        n_pos = mrfr_pkg::OFS_CRC_HI;
                    end else begin
                        n_status = crc_ok ? mrfr_pkg::ST_GOOD : mrfr_pkg::ST_CRC_BAD;
                        n_busy   = crc_ok;
                        n_phase  = mrfr_pkg::PH_WAIT_ADDR;
                        n_pos    = 8'd0;
                    end
                end
                mrfr_pkg::PH_PAYLOAD: begin
                    n_index  = r_pos;
                    n_status = mrfr_pkg::ST_IN_FRAME;
                    if (pos_p2 < r_exp) begin
                        n_crc = crc_fed;
                    end
                    if (pos_p1 >= r_exp) begin
                        n_status = crc_ok ? mrfr_pkg::ST_GOOD : mrfr_pkg::ST_CRC_BAD;
                        n_busy   = crc_ok;
                        n_phase  = mrfr_pkg::PH_WAIT_ADDR;
                        n_pos    = 8'd0;
                    end else begin
                        n_pos = pos_p1[7:0];
                    end
                end
                default: begin
                    n_phase = mrfr_pkg::PH_WAIT_ADDR;
                    n_pos   = 8'd0;
                end
            endcase
        end

        // Last byte taken into a frame
        if (!i_q_item.is_release && n_status != mrfr_pkg::ST_BUSY &&
            n_status != mrfr_pkg::ST_IGNORED) begin
            n_prev = b;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mrfr_pkg::PH_WAIT_ADDR;
            r_pos   <= 8'd0;
            r_exp   <= 9'd0;
            r_crc   <= mrfr_pkg::CRC_INIT;
            r_prev  <= 8'd0;
            r_busy  <= 1'b0;
            r_hfunc <= 8'd0;
            r_hreg  <= 16'd0;
            r_hqty  <= 16'd0;
            r_hcnt  <= 8'd0;
        end else if (o_q_pop) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_crc   <= n_crc;
            r_prev  <= n_prev;
            r_busy  <= n_busy;
            r_hfunc <= n_hfunc;
            r_hreg  <= n_hreg;
            r_hqty  <= n_hqty;
            r_hcnt  <= n_hcnt;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_index  <= n_index;
        end
    end

    // Header held in state already reflects the transfer just taken
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {r_hcnt, r_hqty, r_hreg, r_hfunc, r_index, r_value};

endmodule

// ===== hdl/modbus_rtu_frame_receiver.sv =====
// Top level of the Modbus RTU slave frame receiver.
//
//  Channel  Dir  Handshake            Contents
//  s_axis   in   tvalid/tready        tuser: command; tdata: rx_byte
//  m_axis   out  tvalid/tready        tuser: status; tdata: byte and header fields
//  cfg      in   i_cfg_we             i_cfg_wdata: slave_address
//
// One transfer per cycle sustained while the result side is ready; a byte is written into
// the queue at its input edge, and the frame engine pops it from there into its result
// register, from which the result transfer is made.
// The frame engine handles one byte per cycle when not stalled: CRC byte update and compare.
// Reset is synchronous, active low; no clearing pass, ready right after reset.
// A stalled output holds its result while the two-entry queue absorbs input.
module modbus_rtu_frame_receiver #(
    parameter int MAX_FRAME_BYTES = mrfr_pkg::MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] byte_value, [15:8] byte_index,
                                        // [23:16] function_code, [39:24] start_register,
                                        // [55:40] quantity, [63:56] data_byte_count
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    logic            q_ready;
    logic            q_push;
    mrfr_pkg::t_item q_in;
    logic            q_valid;
    logic            q_pop;
    mrfr_pkg::t_item q_out;

    mrfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_ready     (q_ready),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    mrfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    mrfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Modbus RTU slave frame receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   LONG_HOLD   = 64;

    // One result transfer as seen on the master side
    typedef struct {
        logic [2:0]  status;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic [7:0]  function_code;
        logic [15:0] start_register;
        logic [15:0] quantity;
        logic [7:0]  data_byte_count;
    } t_rx_report;

    // Frame tracker: mirrors the receiver state and holds the reports still due
    class t_frame_tracker;
        logic [7:0]  address;
        logic [1:0]  phase;
        int          position;
        int          frame_len;
        logic [15:0] crc;
        logic [7:0]  last_byte;
        bit          busy;
        logic [7:0]  hdr_func;
        logic [15:0] hdr_reg;
        logic [15:0] hdr_qty;
        logic [7:0]  hdr_count;
        t_rx_report  due[$];
        int          errors;
        int          seen[8];

        function new();
            address   = mrfr_pkg::ADDR_RESET;
            phase     = mrfr_pkg::PH_WAIT_ADDR;
            position  = 0;
            frame_len = 0;
            crc       = mrfr_pkg::CRC_INIT;
            last_byte = 8'h00;
            busy      = 1'b0;
            hdr_func  = 8'h00;
            hdr_reg   = 16'h0000;
            hdr_qty   = 16'h0000;
            hdr_count = 8'h00;
            errors    = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        // Bit-serial reflected CRC-16, LSB first
        static function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] din);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb  = acc[0] ^ din[i];
                acc = acc >> 1;
                if (fb) begin
                    acc = acc ^ mrfr_pkg::CRC_POLY;
                end
            end
            return acc;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Predict the report for one accepted input transfer
        function void take_item(logic cmd, logic [7:0] b);
            t_rx_report r;
            int         idx;
            bit         crc_ok;
            r.status     = mrfr_pkg::ST_IGNORED;
            r.byte_value = b;
            idx          = 0;
            crc_ok       = (last_byte == crc[7:0]) && (b == crc[15:8]);
            if (cmd == CMD_RELEASE) begin
                busy         = 1'b0;
                phase        = mrfr_pkg::PH_WAIT_ADDR;
                position     = 0;
                r.status     = mrfr_pkg::ST_RELEASED;
                r.byte_value = 8'h00;
            end else if (busy) begin
                r.status = mrfr_pkg::ST_BUSY;
            end else begin
                unique case (phase)
                    mrfr_pkg::PH_WAIT_ADDR: begin
                        if (b == address) begin
                            hdr_func  = 8'h00;
                            hdr_reg   = 16'h0000;
                            hdr_qty   = 16'h0000;
                            hdr_count = 8'h00;
                            crc       = crc16_step(mrfr_pkg::CRC_INIT, b);
                            position  = 1;
                            phase     = mrfr_pkg::PH_HEADER;
                            r.status  = mrfr_pkg::ST_IN_FRAME;
                        end
                    end
                    mrfr_pkg::PH_HEADER: begin
                        idx = position;
                        // header capture by offset
                        unique case (idx)
                            mrfr_pkg::OFS_FUNC:   hdr_func       = b;
                            mrfr_pkg::OFS_REG_HI: hdr_reg[15:8]  = b;
                            mrfr_pkg::OFS_REG_LO: hdr_reg[7:0]   = b;
                            mrfr_pkg::OFS_QTY_HI: hdr_qty[15:8]  = b;
                            mrfr_pkg::OFS_QTY_LO: hdr_qty[7:0]   = b;
                            mrfr_pkg::OFS_COUNT: begin
                                if (hdr_func == mrfr_pkg::FC_WRITE_MULTI) hdr_count = b;
                            end
                            default: ;
                        endcase
                        r.status = mrfr_pkg::ST_IN_FRAME;
                        if (idx <= mrfr_pkg::OFS_QTY_LO) begin
                            crc      = crc16_step(crc, b);
                            position = idx + 1;
                        end else if (idx == mrfr_pkg::OFS_COUNT &&
                                     hdr_func == mrfr_pkg::FC_WRITE_MULTI) begin
                            crc       = crc16_step(crc, b);
                            frame_len = mrfr_pkg::WM_OVERHEAD + b;
                            if (frame_len > mrfr_pkg::MAX_FRAME_BYTES) begin
                                r.status = mrfr_pkg::ST_TOO_LONG;
                                phase    = mrfr_pkg::PH_WAIT_ADDR;
                                position = 0;
                            end else begin
                                phase    = mrfr_pkg::PH_PAYLOAD;
                                position = mrfr_pkg::OFS_CRC_HI;
                            end
                        end else if (idx == mrfr_pkg::OFS_COUNT) begin
                            position = mrfr_pkg::OFS_CRC_HI;
                        end else begin
                            r.status = crc_ok ? mrfr_pkg::ST_GOOD : mrfr_pkg::ST_CRC_BAD;
                            busy     = crc_ok;
                            phase    = mrfr_pkg::PH_WAIT_ADDR;
                            position = 0;
                        end
                    end
                    mrfr_pkg::PH_PAYLOAD: begin
                        idx      = position;
                        r.status = mrfr_pkg::ST_IN_FRAME;
                        if (idx + 2 < frame_len) begin
                            crc = crc16_step(crc, b);
                        end
                        if (idx + 1 >= frame_len) begin
                            r.status = crc_ok ? mrfr_pkg::ST_GOOD : mrfr_pkg::ST_CRC_BAD;
                            busy     = crc_ok;
                            phase    = mrfr_pkg::PH_WAIT_ADDR;
                            position = 0;
                        end else begin
                            position = idx + 1;
                        end
                    end
                    default: begin
                        phase    = mrfr_pkg::PH_WAIT_ADDR;
                        position = 0;
                    end
                endcase
            end
            if (cmd == CMD_BYTE && r.status != mrfr_pkg::ST_BUSY &&
                r.status != mrfr_pkg::ST_IGNORED) begin
                last_byte = b;
            end
            r.byte_index      = idx[7:0];
            r.function_code   = hdr_func;
            r.start_register  = hdr_reg;
            r.quantity        = hdr_qty;
            r.data_byte_count = hdr_count;
            due.push_back(r);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_report(logic [2:0] st, logic [63:0] d);
            t_rx_report r;
            if (due.size() == 0) begin
                $error("unexpected result transfer: status %0d data %h", st, d);
                errors++;
                return;
            end
            r = due.pop_front();
            seen[st]++;
            check_field("status", r.status, st);
            check_field("byte_value", r.byte_value, d[7:0]);
            check_field("byte_index", r.byte_index, d[15:8]);
            check_field("function_code", r.function_code, d[23:16]);
            check_field("start_register", r.start_register, d[39:24]);
            check_field("quantity", r.quantity, d[55:40]);
            check_field("data_byte_count", r.data_byte_count, d[63:56]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [7:0] byte_value, [15:8] byte_index,
                                 // [23:16] function_code, [39:24] start_register,
                                 // [55:40] quantity, [63:56] data_byte_count
    logic [2:0]  m_axis_tuser;   // [2:0] status

    t_frame_tracker tracker;
    int             src_idle_pct;
    int             snk_stall_pct;
    bit             long_hold_req;
    int             hold_left;
    int             bytes_sent;
    int             cycles = 0;

    modbus_rtu_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Result side ready: random stalls plus one long hold-off on request
    initial begin
        bit hold_used;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        hold_used     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_report(m_axis_tuser, m_axis_tdata);
        end
    end

    // Offer one item; entered and left just after a falling edge
    task automatic push_item(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_item(cmd, b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Build a request with its CRC and send the first cut bytes (all if cut is 0)
    task automatic send_request(input logic [7:0] addr, input logic [7:0] func,
                                input logic [15:0] reg_addr, input logic [15:0] qty,
                                input int n_data, input bit bad_crc, input int cut);
        logic [7:0]  fr[$];
        logic [15:0] c;
        int          total;
        fr = {addr, func, reg_addr[15:8], reg_addr[7:0], qty[15:8], qty[7:0]};
        if (func == mrfr_pkg::FC_WRITE_MULTI) begin
            fr.push_back(n_data[7:0]);
            for (int i = 0; i < n_data; i++) fr.push_back(8'($urandom_range(255)));
        end
        c = mrfr_pkg::CRC_INIT;
        foreach (fr[i]) c = t_frame_tracker::crc16_step(c, fr[i]);
        if (bad_crc) c ^= 16'($urandom_range(1, 65535));
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        total = (cut > 0 && cut < fr.size()) ? cut : fr.size();
        for (int i = 0; i < total; i++) push_item(CMD_BYTE, fr[i]);
    endtask

    // Address change only once all reports are in
    task automatic write_address(input logic [7:0] a);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        tracker.address = a;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random sequence: mostly well-formed frames, some broken, some noise
    task automatic random_sequence(input logic [7:0] addr);
        int         pick;
        int         r;
        int         n;
        logic [7:0] fc;
        pick = $urandom_range(99);
        r    = $urandom_range(9);
        fc   = (r < 4) ? mrfr_pkg::FC_WRITE_MULTI : (r == 4) ? 8'h03 : (r == 5) ? 8'h06 :
               8'($urandom_range(255));
        r    = $urandom_range(99);
        n    = (r < 1) ? mrfr_pkg::MAX_FRAME_BYTES - mrfr_pkg::WM_OVERHEAD :
               (r < 4) ? $urandom_range(mrfr_pkg::MAX_FRAME_BYTES - mrfr_pkg::WM_OVERHEAD + 1,
                                        255) :
               $urandom_range(0, 12);
        if (pick < 70) begin
            send_request(addr, fc, 16'($urandom), 16'($urandom), n,
                         $urandom_range(99) < 15,
                         (fc == mrfr_pkg::FC_WRITE_MULTI &&
                          n + mrfr_pkg::WM_OVERHEAD > mrfr_pkg::MAX_FRAME_BYTES) ? 7 : 0);
            repeat ($urandom_range(0, 2)) push_item(CMD_BYTE, 8'($urandom_range(255)));
            if ($urandom_range(9) != 0) push_item(CMD_RELEASE, 8'($urandom_range(255)));
        end else if (pick < 85) begin
            // truncated frame, sometimes aborted by a release
            send_request(addr, fc, 16'($urandom), 16'($urandom), n % 13, 1'b0,
                         $urandom_range(1, 7));
            if ($urandom_range(1)) push_item(CMD_RELEASE, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                push_item($urandom_range(99) < 20, 8'($urandom_range(255)));
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [7:0] addr;
        int         target;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = CMD_BYTE;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray byte, good request, busy byte, release,
        // CRC error, oversize write-multiple, release while waiting
        addr = mrfr_pkg::ADDR_RESET;
        push_item(CMD_BYTE, 8'h55);
        send_request(addr, 8'h03, 16'h0000, 16'hFFFF, 0, 1'b0, 0);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_RELEASE, 8'hFF);
        send_request(addr, 8'hFF, 16'hFFFF, 16'h0000, 0, 1'b1, 0);
        send_request(addr, mrfr_pkg::FC_WRITE_MULTI, 16'h1234, 16'h0002,
                     mrfr_pkg::MAX_FRAME_BYTES - mrfr_pkg::WM_OVERHEAD + 1, 1'b0, 7);
        push_item(CMD_RELEASE, 8'h00);

        // Random phases over addresses and handshake pressure
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       addr = mrfr_pkg::ADDR_RESET;
                1:       addr = 8'h00;
                2:       addr = 8'hFF;
                default: addr = 8'($urandom_range(255));
            endcase
            if (ph > 0) write_address(addr);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
                default: begin src_idle_pct = 13; snk_stall_pct = 13; end
            endcase
            if (ph == 0) long_hold_req = 1'b1;
            target = bytes_sent + 285;
            while (bytes_sent < target) random_sequence(addr);
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("%0d byte/release transfers over 6 address settings in %0d cycles",
                 bytes_sent, cycles);
        $display("good %0d, crc errors %0d, oversize %0d, busy %0d, releases %0d, errors %0d",
                 tracker.seen[mrfr_pkg::ST_GOOD], tracker.seen[mrfr_pkg::ST_CRC_BAD],
                 tracker.seen[mrfr_pkg::ST_TOO_LONG], tracker.seen[mrfr_pkg::ST_BUSY],
                 tracker.seen[mrfr_pkg::ST_RELEASED], tracker.errors);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
